[rtl/pfa_pkg.sv]
// Package for the partition fit allocator: table entry type, codes and sizes.
// Used by pfa_table and partition_fit_allocator; depends on nothing else.
package pfa_pkg;

  localparam int MAX_PARTITIONS = 32;
  localparam int IDX_W          = 5;
  localparam int CNT_W          = 6;
  localparam int ADDR_BITS      = 20;
  localparam int SIZE_W         = 21;
  localparam int OWNER_W        = 16;

  localparam logic [SIZE_W-1:0] SPACE_TOP = 21'h100000;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOOWNER = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] CFG_FIXED  = 2'd0;
  localparam logic [1:0] CFG_POLICY = 2'd1;
  localparam logic [1:0] CFG_MEMSZ  = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    size;
    logic                 used;
    logic [OWNER_W-1:0]   owner;
  } pfa_entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_APP_RD, S_APP_WR, S_SCAN, S_DECIDE,
    S_SHUP, S_SPLIT_LO, S_SPLIT_HI, S_SHDN, S_DONE
  } pfa_state_t;

endpackage

[rtl/pfa_table.sv]
// Partition table memory: one write port, one read port, registered read data.
// Depends on pfa_pkg for the entry type and table depth.
module pfa_table
  import pfa_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  pfa_entry_t       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output pfa_entry_t       rd_data
);

  pfa_entry_t mem [MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/partition_fit_allocator.sv]
// Top level of the partition fit allocator: transaction handshakes, control
// sequencer and result register. Depends on pfa_pkg and pfa_table.

// The block keeps a table of up to 32 contiguous memory partitions in a
// single-port-read, single-port-write memory and serves one request at a time.
// Every input transaction gives exactly one result transaction. Its duration
// is set by the table memory, which is read one entry per cycle: allocate,
// check space and free scan every entry in use, and a split or merge in
// dynamic mode then moves the entries behind the chosen one. A new request is
// taken as soon as the previous one has reached the result register, even
// while that result still waits to be taken. Configuration writes are always
// accepted and must only be issued while the block is idle.
module partition_fit_allocator
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           opcode,
  input  logic [OWNER_W-1:0]   owner_id,
  input  logic [SIZE_W-1:0]    request_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [ADDR_BITS-1:0] granted_base,
  output logic [IDX_W-1:0]     slot_index
);

  // Configuration registers.
  logic              fixed_mode;
  logic [1:0]        fit_policy;
  logic [SIZE_W-1:0] memory_size;

  // Sequencer state and its next values.
  pfa_state_t state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [2:0]           op_q, op_q_next;
  logic [OWNER_W-1:0]   own_q, own_q_next;
  logic [SIZE_W-1:0]    req_q, req_q_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic                 pend, pend_next;
  logic [IDX_W-1:0]     pend_idx, pend_idx_next;
  logic                 found, found_next;
  logic [IDX_W-1:0]     pick, pick_next;
  logic [ADDR_BITS-1:0] pbase, pbase_next;
  logic [SIZE_W-1:0]    psize, psize_next;
  logic                 prv_used, prv_used_next;
  logic [ADDR_BITS-1:0] prv_base, prv_base_next;
  logic [SIZE_W-1:0]    prv_size, prv_size_next;
  logic                 lft_used, lft_used_next;
  logic [ADDR_BITS-1:0] lft_base, lft_base_next;
  logic [SIZE_W-1:0]    lft_size, lft_size_next;
  logic                 has_next, has_next_next;
  logic                 nxt_used, nxt_used_next;
  logic [SIZE_W-1:0]    nxt_size, nxt_size_next;
  logic [1:0]           shd, shd_next;
  logic [1:0]           res_status, res_status_next;
  logic [ADDR_BITS-1:0] res_base, res_base_next;
  logic [IDX_W-1:0]     res_slot, res_slot_next;
  logic                 out_valid_next;
  logic [1:0]           status_next;
  logic [ADDR_BITS-1:0] granted_base_next;
  logic [IDX_W-1:0]     slot_index_next;

  // Table memory ports.
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  pfa_entry_t       wr_data, rd_data;

  // Working values of the sequencer.
  logic [1:0]        pol;
  logic              fits, match, take;
  logic [SIZE_W:0]   nb;
  logic [SIZE_W+1:0] app_end;
  logic              rgt, lft;
  logic [SIZE_W-1:0] msize;
  logic [IDX_W-1:0]  tgt;

  pfa_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_mode  <= 1'b0;
      fit_policy  <= POL_FIRST;
      memory_size <= 21'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIXED:  fixed_mode  <= cfg_data[0];
        CFG_POLICY: fit_policy  <= cfg_data[1:0];
        CFG_MEMSZ:  memory_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q         <= op_q_next;
    own_q        <= own_q_next;
    req_q        <= req_q_next;
    idx          <= idx_next;
    pend_idx     <= pend_idx_next;
    found        <= found_next;
    pick         <= pick_next;
    pbase        <= pbase_next;
    psize        <= psize_next;
    prv_used     <= prv_used_next;
    prv_base     <= prv_base_next;
    prv_size     <= prv_size_next;
    lft_used     <= lft_used_next;
    lft_base     <= lft_base_next;
    lft_size     <= lft_size_next;
    has_next     <= has_next_next;
    nxt_used     <= nxt_used_next;
    nxt_size     <= nxt_size_next;
    shd          <= shd_next;
    res_status   <= res_status_next;
    res_base     <= res_base_next;
    res_slot     <= res_slot_next;
    status       <= status_next;
    granted_base <= granted_base_next;
    slot_index   <= slot_index_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    op_q_next         = op_q;
    own_q_next        = own_q;
    req_q_next        = req_q;
    idx_next          = idx;
    pend_next         = 1'b0;
    pend_idx_next     = pend_idx;
    found_next        = found;
    pick_next         = pick;
    pbase_next        = pbase;
    psize_next        = psize;
    prv_used_next     = prv_used;
    prv_base_next     = prv_base;
    prv_size_next     = prv_size;
    lft_used_next     = lft_used;
    lft_base_next     = lft_base;
    lft_size_next     = lft_size;
    has_next_next     = has_next;
    nxt_used_next     = nxt_used;
    nxt_size_next     = nxt_size;
    shd_next          = shd;
    res_status_next   = res_status;
    res_base_next     = res_base;
    res_slot_next     = res_slot;
    status_next       = status;
    granted_base_next = granted_base;
    slot_index_next   = slot_index;
    out_valid_next    = out_valid && !out_ready;
    wr_en             = 1'b0;
    wr_addr           = pick;
    wr_data           = '0;
    rd_en             = 1'b0;
    rd_addr           = idx[IDX_W-1:0];

    // Check space always uses first fit; the unused policy code acts so too.
    pol   = (op_q == OP_CHECK) ? POL_FIRST : fit_policy;
    fits  = !rd_data.used && (rd_data.size >= req_q);
    match = rd_data.used && (rd_data.owner == own_q);
    take  = 1'b0;
    nb    = (count == '0) ? '0 : ({1'b0, rd_data.base} + {1'b0, rd_data.size});
    app_end = {1'b0, nb} + {2'b00, req_q};
    rgt   = has_next && !nxt_used;
    lft   = (pick != '0) && !lft_used;
    msize = psize + (rgt ? nxt_size : '0) + (lft ? lft_size : '0);
    tgt   = lft ? (pick - 1'b1) : pick;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next       = opcode;
          own_q_next      = owner_id;
          req_q_next      = request_size;
          res_status_next = ST_OK;
          res_base_next   = '0;
          res_slot_next   = '0;
          idx_next        = '0;
          found_next      = 1'b0;
          has_next_next   = 1'b0;
          case (opcode)
            OP_INIT:   state_next = S_INIT;
            OP_APPEND: state_next = S_APP_RD;
            OP_ALLOC,
            OP_FREE,
            OP_CHECK:  state_next = S_SCAN;
            default:   state_next = S_DONE;
          endcase
        end
      end

      S_INIT: begin
        // Dynamic mode starts with one free partition covering user memory.
        if (!fixed_mode && memory_size != '0) begin
          wr_en        = 1'b1;
          wr_addr      = '0;
          wr_data.size = (memory_size > SPACE_TOP) ? SPACE_TOP : memory_size;
          count_next   = CNT_W'(1);
        end else begin
          count_next = '0;
        end
        state_next = S_DONE;
      end

      S_APP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = IDX_W'(count - 1'b1);
        state_next = S_APP_WR;
      end

      S_APP_WR: begin
        if (count[CNT_W-1]) begin
          res_status_next = ST_FULL;
        end else if (req_q == '0 || app_end > {2'b00, SPACE_TOP}) begin
          res_status_next = ST_NOSPACE;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = count[IDX_W-1:0];
          wr_data.base  = nb[ADDR_BITS-1:0];
          wr_data.size  = req_q;
          res_base_next = nb[ADDR_BITS-1:0];
          res_slot_next = count[IDX_W-1:0];
          count_next    = count + 1'b1;
        end
        state_next = S_DONE;
      end

      S_SCAN: begin
        // Reads are issued one entry a cycle; the entry read in the previous
        // cycle is examined in this one.
        if (idx < count) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = idx + 1'b1;
        end else if (!pend) begin
          state_next = S_DECIDE;
        end
        if (pend) begin
          if (op_q == OP_FREE) begin
            if (!found && match) begin
              take          = 1'b1;
              lft_used_next = prv_used;
              lft_base_next = prv_base;
              lft_size_next = prv_size;
            end else if (found && !has_next &&
                         ({1'b0, pend_idx} == {1'b0, pick} + 1'b1)) begin
              has_next_next = 1'b1;
              nxt_used_next = rd_data.used;
              nxt_size_next = rd_data.size;
            end
          end else if (fits) begin
            if (!found) begin
              take = 1'b1;
            end else if (pol == POL_BEST && rd_data.size < psize) begin
              take = 1'b1;
            end else if (pol == POL_WORST && rd_data.size > psize) begin
              take = 1'b1;
            end
          end
          if (take) begin
            found_next = 1'b1;
            pick_next  = pend_idx;
            pbase_next = rd_data.base;
            psize_next = rd_data.size;
          end
          prv_used_next = rd_data.used;
          prv_base_next = rd_data.base;
          prv_size_next = rd_data.size;
        end
      end

      S_DECIDE: begin
        state_next = S_DONE;
        if (op_q == OP_FREE) begin
          if (!found) begin
            res_status_next = ST_NOOWNER;
          end else if (fixed_mode) begin
            wr_en         = 1'b1;
            wr_data.base  = pbase;
            wr_data.size  = psize;
            res_base_next = pbase;
            res_slot_next = pick;
          end else begin
            // Coalesce with free neighbours, then close the gap they leave.
            wr_en         = 1'b1;
            wr_addr       = tgt;
            wr_data.base  = lft ? lft_base : pbase;
            wr_data.size  = msize;
            res_base_next = lft ? lft_base : pbase;
            res_slot_next = tgt;
            shd_next      = {1'b0, rgt} + {1'b0, lft};
            idx_next      = (lft ? {1'b0, pick} : ({1'b0, pick} + 1'b1))
                            + {5'd0, rgt} + {5'd0, lft};
            state_next    = S_SHDN;
          end
        end else if (!found || req_q == '0) begin
          res_status_next = ST_NOSPACE;
        end else if (op_q == OP_CHECK) begin
          res_base_next = pbase;
          res_slot_next = pick;
        end else if (fixed_mode || psize == req_q) begin
          wr_en         = 1'b1;
          wr_data.base  = pbase;
          wr_data.size  = psize;
          wr_data.used  = 1'b1;
          wr_data.owner = own_q;
          res_base_next = pbase;
          res_slot_next = pick;
        end else if (count[CNT_W-1]) begin
          res_status_next = ST_FULL;
        end else begin
          // Split: move the entries behind the chosen one up by one slot.
          res_base_next = pbase;
          res_slot_next = pick;
          idx_next      = count - 1'b1;
          state_next    = S_SHUP;
        end
      end

      S_SHUP: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx + 1'b1;
          wr_data = rd_data;
        end
        if (idx > {1'b0, pick}) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = idx - 1'b1;
        end else if (!pend) begin
          state_next = S_SPLIT_LO;
        end
      end

      S_SPLIT_LO: begin
        wr_en         = 1'b1;
        wr_data.base  = pbase;
        wr_data.size  = req_q;
        wr_data.used  = 1'b1;
        wr_data.owner = own_q;
        state_next    = S_SPLIT_HI;
      end

      S_SPLIT_HI: begin
        wr_en        = 1'b1;
        wr_addr      = pick + 1'b1;
        wr_data.base = pbase + req_q[ADDR_BITS-1:0];
        wr_data.size = psize - req_q;
        count_next   = count + 1'b1;
        state_next   = S_DONE;
      end

      S_SHDN: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - {3'd0, shd};
          wr_data = rd_data;
        end
        if (idx < count) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = idx + 1'b1;
        end else if (!pend) begin
          count_next = count - {4'd0, shd};
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          status_next       = res_status;
          granted_base_next = (res_status == ST_OK) ? res_base : '0;
          slot_index_next   = (res_status == ST_OK) ? res_slot : '0;
          state_next        = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
